FILE: hdl/lppd_pkg.sv
// Shared types and constants of the length-prefixed packet deframer.
// Depends on nothing; imported by the deframer core.
package lppd_pkg;

  // Frame geometry
  localparam int FRAME_BYTES  = 64;
  localparam int HEADER_BYTES = 4;
  localparam int PAYLOAD_MAX  = FRAME_BYTES - HEADER_BYTES;
  localparam int ADDR_W       = $clog2(PAYLOAD_MAX);
  localparam int CNT_W        = $clog2(FRAME_BYTES);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CODE_W = 16;
  localparam int KIND_W = 3;
  localparam int PLEN_W = 6;
  localparam int CFG_IDX_W = 2;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_PACKET     = 3'd0;
  localparam logic [KIND_W-1:0] EV_PEER_ENDED = 3'd1;
  localparam logic [KIND_W-1:0] EV_GOODBYE    = 3'd2;
  localparam logic [KIND_W-1:0] EV_LINK_LOST  = 3'd3;
  localparam logic [KIND_W-1:0] EV_BAD_LENGTH = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_END_CONN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOODBYE  = 2'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              link_failed;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [CODE_W-1:0] frame_type;
    logic [PLEN_W-1:0] payload_len;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic              link_lost_flag;
    logic              peer_ended_flag;
  } out_item_t;

endpackage

FILE: hdl/length_prefixed_packet_deframer_core.sv
// Length-prefixed packet deframer core: header parse, payload memory, replay.
// Depends on lppd_pkg for item types, frame geometry and event codes.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_stall   | in_item  (rx_byte, link_failed)
//   out     | output    | out_valid/out_stall | out_item (event and byte result)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// A header or payload byte is accepted while the output is free. A completed
// frame replays its payload byte by byte, each a read of the payload memory
// (registered read port) then an output register load, with the input stalled.
// Reset clears all control state and both codes; the payload memory is not
// cleared. A stalled output holds the input stalled while a result is ready.
// After a bad length the block drops every item until reset.
module length_prefixed_packet_deframer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lppd_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lppd_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lppd_pkg::CODE_W-1:0] cfg_data
);
  import lppd_pkg::*;

  localparam logic [1:0] ST_RECV = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_HALT = 2'd3;

  localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_BYTES);

  logic [1:0]        state, state_next;
  logic [CODE_W-1:0] end_code, goodbye_code;
  logic [CODE_W-1:0] header_type, header_type_next;
  logic [CODE_W-1:0] decl_len, decl_len_next;
  logic [CNT_W-1:0]  bytes_rcvd, bytes_rcvd_next;
  logic [CNT_W-1:0]  target, target_next;
  logic [CNT_W-1:0]  cnt;
  logic              lost, lost_next, ended, ended_next;
  logic [KIND_W-1:0] kind, kind_next, kind_c;
  logic [PLEN_W-1:0] plen, plen_next, plen_c;
  logic [ADDR_W-1:0] rd_addr, rd_addr_next;
  logic [BYTE_W-1:0] rd_data;
  logic              frame_done;

  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_MAX];

  logic              in_acc, out_free, load;
  out_item_t         res;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_RECV && out_free) || state == ST_HALT);
  assign in_acc   = in_valid && !in_stall;
  assign cnt      = bytes_rcvd + 1'b1;
  assign wr_addr  = ADDR_W'(bytes_rcvd - HDR_CNT);

  // Parse the stream, decide results and sequence the replay
  always_comb begin
    state_next       = state;
    header_type_next = header_type;
    decl_len_next    = decl_len;
    bytes_rcvd_next  = bytes_rcvd;
    target_next      = target;
    lost_next        = lost;
    ended_next       = ended;
    kind_next        = kind;
    plen_next        = plen;
    rd_addr_next     = rd_addr;
    mem_we           = 1'b0;
    load             = 1'b0;
    res              = '0;
    frame_done       = 1'b0;
    kind_c           = EV_PACKET;
    plen_c           = '0;
    case (state)
      ST_RECV: begin
        if (in_acc) begin
          if (in_item.link_failed) begin
            lost_next           = 1'b1;
            load                = 1'b1;
            res.event_kind      = EV_LINK_LOST;
            res.last_of_run     = 1'b1;
            res.link_lost_flag  = 1'b1;
            res.peer_ended_flag = ended;
          end else begin
            // Shift header fields in, store payload bytes
            if (bytes_rcvd < CNT_W'(2)) begin
              header_type_next = {header_type[BYTE_W-1:0], in_item.rx_byte};
            end else if (bytes_rcvd < HDR_CNT) begin
              decl_len_next = {decl_len[BYTE_W-1:0], in_item.rx_byte};
            end else begin
              mem_we = 1'b1;
            end
            bytes_rcvd_next = cnt;
            if (cnt >= target) begin
              if (cnt == HDR_CNT) begin
                if (decl_len_next >= CODE_W'(FRAME_BYTES) ||
                    decl_len_next < CODE_W'(HEADER_BYTES)) begin
                  state_next          = ST_HALT;
                  load                = 1'b1;
                  res.event_kind      = EV_BAD_LENGTH;
                  res.frame_type      = header_type_next;
                  res.last_of_run     = 1'b1;
                  res.link_lost_flag  = lost;
                  res.peer_ended_flag = ended;
                end else begin
                  target_next = decl_len_next[CNT_W-1:0];
                  frame_done  = (CODE_W'(cnt) >= decl_len_next);
                end
              end else begin
                frame_done = 1'b1;
              end
            end
            // Close the frame: classify, then report it at once if empty or start the replay
            if (frame_done) begin
              plen_c          = PLEN_W'(decl_len_next - CODE_W'(HEADER_BYTES));
              bytes_rcvd_next = '0;
              target_next     = HDR_CNT;
              if (header_type_next == end_code) begin
                ended_next = 1'b1;
                kind_c     = EV_PEER_ENDED;
              end else if (header_type_next == goodbye_code) begin
                lost_next = 1'b1;
                kind_c    = EV_GOODBYE;
              end
              if (plen_c == '0) begin
                load                = 1'b1;
                res.event_kind      = kind_c;
                res.frame_type      = header_type_next;
                res.last_of_run     = 1'b1;
                res.link_lost_flag  = lost_next;
                res.peer_ended_flag = ended_next;
              end else begin
                state_next   = ST_RD;
                kind_next    = kind_c;
                plen_next    = plen_c;
                rd_addr_next = '0;
              end
            end
          end
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          load                = 1'b1;
          res.event_kind      = kind;
          res.frame_type      = header_type;
          res.payload_len     = plen;
          res.data_byte       = rd_data;
          res.byte_valid      = 1'b1;
          res.last_of_run     = (PLEN_W'(rd_addr) == plen - 1'b1);
          res.link_lost_flag  = lost;
          res.peer_ended_flag = ended;
          if (res.last_of_run) begin
            state_next = ST_RECV;
          end else begin
            rd_addr_next = rd_addr + 1'b1;
            state_next   = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_HALT;
      end
    endcase
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[wr_addr] <= in_item.rx_byte;
    end
    if (state == ST_RD) begin
      rd_data <= payload_mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RECV;
      end_code     <= '0;
      goodbye_code <= '0;
      header_type  <= '0;
      decl_len     <= '0;
      bytes_rcvd   <= '0;
      target       <= HDR_CNT;
      lost         <= 1'b0;
      ended        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state       <= state_next;
      header_type <= header_type_next;
      decl_len    <= decl_len_next;
      bytes_rcvd  <= bytes_rcvd_next;
      target      <= target_next;
      lost        <= lost_next;
      ended       <= ended_next;
      if (cfg_we && cfg_index == CFG_END_CONN) begin
        end_code <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_GOODBYE) begin
        goodbye_code <= cfg_data;
      end
      // Hold the result until taken, then load or drop valid
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Replay context and output payload
  always_ff @(posedge clk) begin
    kind    <= kind_next;
    plen    <= plen_next;
    rd_addr <= rd_addr_next;
    if (load) begin
      out_item <= res;
    end
  end

endmodule
